// File: sv/assert_macros.svh
// Assertion macros used by the top level, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle, sampled on clk, off during reset.
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property whose consequence must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/mrf_pkg.sv
// Types, constants and register codes of the mouse report framer.
package mrf_pkg;

	// Default width of the tracked cursor position.
	localparam int POSITION_BITS_DEF = 12;

	// Frame layout: five bytes, sent twice.
	localparam int FRAME_BYTES = 5;
	localparam int FRAME_COPIES = 2;
	localparam int TOTAL_BYTES = FRAME_BYTES * FRAME_COPIES;
	localparam int COUNT_BITS = $clog2(TOTAL_BYTES);
	localparam int SEL_BITS = $clog2(FRAME_BYTES);

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Frame headers and delta limits.
	localparam logic [7:0] HDR_MOVE = 8'hC3;
	localparam logic [7:0] HDR_WHEEL = 8'hC5;
	localparam logic signed [7:0] DELTA_LIMIT = 8'sd127;
	localparam logic signed [7:0] WHEEL_STEP = 8'sd120;

	// Configuration port.
	localparam int CFG_INDEX_BITS = 4;
	localparam int SIZE_BITS = 13;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 4'd1;
	localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RST = 13'd1920;
	localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RST = 13'd1080;

	// Cursor fields of the result.
	localparam int CURSOR_BITS = 12;

	typedef struct packed {
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic               is_wheel;
	} mrf_in_t;

	typedef struct packed {
		logic [7:0]             frame_byte;
		logic                   last_byte;
		logic [CURSOR_BITS-1:0] cursor_x;
		logic [CURSOR_BITS-1:0] cursor_y;
	} mrf_out_t;

	// One built frame as it waits for the serialiser.
	typedef struct packed {
		logic [7:0]             hdr;
		logic [7:0]             msg_id;
		logic [7:0]             byte_a;
		logic [7:0]             byte_b;
		logic [7:0]             sum;
		logic [CURSOR_BITS-1:0] cursor_x;
		logic [CURSOR_BITS-1:0] cursor_y;
	} mrf_frame_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic not_empty;
	} mrf_q_status_t;

endpackage

// File: sv/mouse_report_framer.sv
// Top level of the mouse report framer: event front, frame queue and byte serialiser.
//
//   channel   direction  handshake             payload
//   event     in         event_valid/stall     mrf_in_t   (delta_x, delta_y, is_wheel)
//   frame     out        frame_valid/stall     mrf_out_t  (byte, last, cursor x/y)
//   cfg       in         cfg_valid/ready       cfg_index, cfg_data
//
// Each non-empty event gives ten byte transactions, one per cycle while the frame side
// does not stall; the serialiser sets the sustained event rate. An event is taken into the
// queue in the cycle it arrives, so the front keeps accepting while bytes go out.
// Events with both deltas zero are taken at once and produce nothing.
// Reset clears the cursor, the message id and the queue; no clearing pass follows.
// A stall on the frame side holds the current byte; the event side stalls only when
// the queue is full.
module mouse_report_framer #(
	parameter int POSITION_BITS = mrf_pkg::POSITION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               event_valid,
	output logic                               event_stall,
	input  mrf_pkg::mrf_in_t                   event_data,
	output logic                               frame_valid,
	input  logic                               frame_stall,
	output mrf_pkg::mrf_out_t                  frame_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mrf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [mrf_pkg::SIZE_BITS-1:0]      cfg_data
);
	import mrf_pkg::*;

`include "assert_macros.svh"

	logic          push;
	logic          pop;
	mrf_frame_t    push_data;
	mrf_frame_t    pop_data;
	mrf_q_status_t q_status;

	// Front: classify the event and build its frame.
	mrf_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.event_valid(event_valid),
		.event_stall(event_stall),
		.event_data(event_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_status(q_status),
		.push(push),
		.push_data(push_data)
	);

	// Queue of built frames.
	mrf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.pop_data(pop_data),
		.status(q_status)
	);

	// Back: serialise each frame twice.
	mrf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_status(q_status),
		.pop_data(pop_data),
		.pop(pop),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame_data(frame_data)
	);

	// The queue is never written while full.
	`ASSERT_NOW(a_no_push_full, push, !q_status.full, "frame pushed into a full queue")

	// An empty event must not produce a frame.
	`ASSERT_NOW(a_zero_dropped, event_valid && !event_stall && event_data.delta_x == '0 && event_data.delta_y == '0, !push, "empty event produced a frame")

	// After the tenth byte with nothing queued, the output goes idle.
	`ASSERT_NEXT(a_idle_after_last, frame_valid && !frame_stall && frame_data.last_byte && !q_status.not_empty, !frame_valid, "output stayed valid after the last byte")

	// The serialiser only loads from a queue that holds a frame.
	`ASSERT_NOW(a_pop_not_empty, pop, q_status.not_empty, "frame popped from an empty queue")

endmodule

// File: sv/mrf_queue.sv
// Short frame queue between the event front and the byte serialiser.
module mrf_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mrf_pkg::mrf_frame_t    push_data,
	input  logic                   pop,
	output mrf_pkg::mrf_frame_t    pop_data,
	output mrf_pkg::mrf_q_status_t status
);
	import mrf_pkg::*;

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);

	mrf_frame_t           entry_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q;
	logic [PTR_BITS-1:0]  rd_ptr_q;
	logic [FILL_BITS-1:0] fill_q;

	// Status flags from the fill count.
	assign status.full = (fill_q == FILL_BITS'(QUEUE_DEPTH));
	assign status.not_empty = (fill_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Entry storage, written at the write pointer.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: sv/mrf_front.sv
// Event front: takes an event, drops empty ones, tracks the cursor and builds the frame.
module mrf_front #(
	parameter int POSITION_BITS = mrf_pkg::POSITION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                event_valid,
	output logic                                event_stall,
	input  mrf_pkg::mrf_in_t                    event_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mrf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [mrf_pkg::SIZE_BITS-1:0]       cfg_data,
	input  mrf_pkg::mrf_q_status_t              q_status,
	output logic                                push,
	output mrf_pkg::mrf_frame_t                 push_data
);
	import mrf_pkg::*;

	// Bound width covers both the screen size and the position range.
	localparam int HW = (POSITION_BITS > SIZE_BITS) ? POSITION_BITS : SIZE_BITS;
	localparam int SW = HW + 2;

	logic [SIZE_BITS-1:0]     screen_width_q;
	logic [SIZE_BITS-1:0]     screen_height_q;
	logic [POSITION_BITS-1:0] pos_x_q;
	logic [POSITION_BITS-1:0] pos_y_q;
	logic [7:0]               msg_id_q;

	logic                     nonzero;
	logic signed [7:0]        dx_c;
	logic signed [7:0]        dy_c;
	logic [POSITION_BITS-1:0] pos_x_nxt;
	logic [POSITION_BITS-1:0] pos_y_nxt;
	logic [POSITION_BITS-1:0] pos_x_out;
	logic [POSITION_BITS-1:0] pos_y_out;
	logic [POSITION_BITS+CURSOR_BITS-1:0] cur_x_ext;
	logic [POSITION_BITS+CURSOR_BITS-1:0] cur_y_ext;
	logic [7:0]               wheel_b;

	// Clamp one delta to the symmetric byte range.
	function automatic logic signed [7:0] clamp_delta(input logic signed [15:0] d);
		logic signed [7:0] r;
		if (d > DELTA_LIMIT) begin
			r = DELTA_LIMIT;
		end else if (d < -DELTA_LIMIT) begin
			r = -DELTA_LIMIT;
		end else begin
			r = d[7:0];
		end
		return r;
	endfunction

	// Move one axis and clamp to 0..size-1, the bound saturating at the position range.
	function automatic logic [POSITION_BITS-1:0] move_axis(
		input logic [POSITION_BITS-1:0] pos,
		input logic signed [7:0]        d,
		input logic [SIZE_BITS-1:0]     size
	);
		logic [HW-1:0]        hi;
		logic signed [SW-1:0] p;
		logic [POSITION_BITS-1:0] r;
		hi = (size == '0) ? '0 : HW'(size - 1'b1);
		if (hi > HW'({POSITION_BITS{1'b1}})) begin
			hi = HW'({POSITION_BITS{1'b1}});
		end
		p = $signed({2'b00, HW'(pos)}) + SW'(d);
		if (p < 0) begin
			r = '0;
		end else if (p > $signed({2'b00, hi})) begin
			r = POSITION_BITS'(hi);
		end else begin
			r = POSITION_BITS'(p);
		end
		return r;
	endfunction

	// Classification and frame build.
	always_comb begin
		nonzero = (event_data.delta_x != '0) || (event_data.delta_y != '0);
		dx_c = clamp_delta(event_data.delta_x);
		dy_c = clamp_delta(event_data.delta_y);
		pos_x_nxt = move_axis(pos_x_q, dx_c, screen_width_q);
		pos_y_nxt = move_axis(pos_y_q, dy_c, screen_height_q);
		// The clamped wheel amount divided by the step is always -1, 0 or 1.
		if (dx_c >= WHEEL_STEP) begin
			wheel_b = 8'd1;
		end else if (dx_c <= -WHEEL_STEP) begin
			wheel_b = 8'hFF;
		end else begin
			wheel_b = 8'd0;
		end
		pos_x_out = event_data.is_wheel ? pos_x_q : pos_x_nxt;
		pos_y_out = event_data.is_wheel ? pos_y_q : pos_y_nxt;
		cur_x_ext = {{CURSOR_BITS{1'b0}}, pos_x_out};
		cur_y_ext = {{CURSOR_BITS{1'b0}}, pos_y_out};

		push_data.hdr = event_data.is_wheel ? HDR_WHEEL : HDR_MOVE;
		push_data.msg_id = msg_id_q;
		push_data.byte_a = event_data.is_wheel ? wheel_b : dx_c;
		push_data.byte_b = event_data.is_wheel ? 8'd0 : dy_c;
		push_data.sum = push_data.hdr + push_data.msg_id + push_data.byte_a
			+ push_data.byte_b;
		push_data.cursor_x = cur_x_ext[CURSOR_BITS-1:0];
		push_data.cursor_y = cur_y_ext[CURSOR_BITS-1:0];
	end

	// Handshakes: empty events are taken and dropped.
	assign event_stall = q_status.full;
	assign push = event_valid && !q_status.full && nonzero;
	assign cfg_ready = 1'b1;

	// Cursor, message id and screen size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
			pos_x_q <= '0;
			pos_y_q <= '0;
			msg_id_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_SCREEN_WIDTH: begin
						screen_width_q <= cfg_data;
					end
					REG_SCREEN_HEIGHT: begin
						screen_height_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (push) begin
				pos_x_q <= pos_x_out;
				pos_y_q <= pos_y_out;
				msg_id_q <= msg_id_q + 8'd1;
			end
		end
	end

endmodule

// File: sv/mrf_back.sv
// Byte serialiser: sends each queued frame twice, one byte per transaction.
module mrf_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mrf_pkg::mrf_q_status_t q_status,
	input  mrf_pkg::mrf_frame_t    pop_data,
	output logic                   pop,
	output logic                   frame_valid,
	input  logic                   frame_stall,
	output mrf_pkg::mrf_out_t      frame_data
);
	import mrf_pkg::*;

	localparam logic [COUNT_BITS-1:0] LAST = COUNT_BITS'(TOTAL_BYTES - 1);

	mrf_frame_t            rec_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  valid_q;
	logic                  take;
	logic                  done;
	logic [COUNT_BITS-1:0] idx_wide;
	logic [SEL_BITS-1:0]   sel;

	assign take = valid_q && !frame_stall;
	assign done = take && (count_q == LAST);
	assign pop = q_status.not_empty && (!valid_q || done);
	assign frame_valid = valid_q;

	// Byte select within the frame copy.
	always_comb begin
		idx_wide = (count_q >= COUNT_BITS'(FRAME_BYTES)) ?
			count_q - COUNT_BITS'(FRAME_BYTES) : count_q;
		sel = idx_wide[SEL_BITS-1:0];
		case (sel)
			3'd0: frame_data.frame_byte = rec_q.hdr;
			3'd1: frame_data.frame_byte = rec_q.msg_id;
			3'd2: frame_data.frame_byte = rec_q.byte_a;
			3'd3: frame_data.frame_byte = rec_q.byte_b;
			default: frame_data.frame_byte = rec_q.sum;
		endcase
		frame_data.last_byte = (count_q == LAST);
		frame_data.cursor_x = rec_q.cursor_x;
		frame_data.cursor_y = rec_q.cursor_y;
	end

	// Byte counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				count_q <= '0;
			end else if (done) begin
				valid_q <= 1'b0;
			end else if (take) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Frame being sent.
	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= pop_data;
		end
	end

endmodule
